/* rtl/rar_pkg.sv */
`default_nettype none
package rar_pkg;

    localparam int WIDTH = 32;        // operand width, 8..32
    localparam int PW    = 2 * WIDTH; // exact width of products and sums
    localparam int CW    = $clog2(PW);

    localparam logic       OP_REDUCE = 1'b0;
    localparam logic       OP_ADD    = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic             neg;
        logic [WIDTH-1:0] mag;
    } t_sm;

    // one job handed from the front to the back
    typedef struct packed {
        logic          zden;
        logic          neg;
        logic [PW-1:0] nmag;
        logic [PW-1:0] dmag;
    } t_job;

    // low WIDTH bits as a signed value, split into sign and magnitude
    function automatic t_sm split_value(input logic [31:0] raw);
        logic [WIDTH-1:0] v;
        t_sm              r;
        v     = raw[WIDTH-1:0];
        r.neg = v[WIDTH-1];
        r.mag = v[WIDTH-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/rar_front.sv */
`default_nettype none
module rar_front import rar_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,
    input  wire logic         i_s_tuser,
    output logic              o_push,
    output t_job              o_job,
    input  wire logic         i_full
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic          r_op, r_zden;
    t_sm           r_na, r_da, r_nb, r_db;
    logic [PW-1:0] r_pa, r_pb, r_pd;

    t_sm           sna, sda, snb, sdb;
    logic          in_op;
    logic [PW-1:0] nmag;
    logic          nneg, spa, spb;

    assign in_op = i_s_tuser;
    assign sna   = split_value(i_s_tdata[31:0]);
    assign sda   = split_value(i_s_tdata[63:32]);
    assign snb   = split_value(i_s_tdata[95:64]);
    assign sdb   = split_value(i_s_tdata[127:96]);

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        spa = r_na.neg ^ r_db.neg;
        spb = r_da.neg ^ r_nb.neg;
        if (spa == spb) begin
            nmag = r_pa + r_pb;
            nneg = spa;
        end else if (r_pa >= r_pb) begin
            nmag = r_pa - r_pb;
            nneg = spa;
        end else begin
            nmag = r_pb - r_pa;
            nneg = spb;
        end
        o_job.zden = r_zden;
        if (r_op == OP_REDUCE) begin
            o_job.nmag = PW'(r_na.mag);
            o_job.dmag = PW'(r_da.mag);
            o_job.neg  = r_na.neg ^ r_da.neg;
        end else begin
            o_job.nmag = nmag;
            o_job.dmag = r_pd;
            o_job.neg  = nneg ^ r_da.neg ^ r_db.neg;
        end
    end

    assign o_push = (r_state == S_PUSH) && !i_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_s_tvalid) n_state = S_MUL;
            S_MUL:  n_state = S_PUSH;
            S_PUSH: if (!i_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_op   <= in_op;
            r_na   <= sna;
            r_da   <= sda;
            r_nb   <= snb;
            r_db   <= sdb;
            r_zden <= (sda.mag == '0) || (in_op == OP_ADD && sdb.mag == '0);
        end
        if (r_state == S_MUL) begin
            r_pa <= PW'(r_na.mag) * PW'(r_db.mag);
            r_pb <= PW'(r_da.mag) * PW'(r_nb.mag);
            r_pd <= PW'(r_da.mag) * PW'(r_db.mag);
        end
    end

endmodule
`default_nettype wire

/* rtl/rar_fifo.sv */
`default_nettype none
module rar_fifo import rar_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

/* rtl/rar_back.sv */
`default_nettype none
module rar_back import rar_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_job             i_job,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,
    output logic [1:0]       o_m_tuser
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_GCD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [PW-1:0] r_a, r_b, r_g, r_n, r_d, r_nrem, r_drem;
    logic [CW-1:0] r_k, r_cnt;
    logic          r_neg;
    logic [1:0]    r_st;

    logic          r_out_valid;
    logic [31:0]   r_res_num;
    logic [30:0]   r_res_den;
    logic [1:0]    r_status;

    logic [PW:0]      ns, ds;
    logic             nge, dge;
    logic [PW-1:0]    limit;
    logic             ovf, out_free;
    logic [WIDTH-1:0] nw;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_free = !r_out_valid || i_m_tready;

    // one restoring step per cycle for both quotients, same divisor
    assign ns  = {r_nrem, r_n[PW-1]};
    assign ds  = {r_drem, r_d[PW-1]};
    assign nge = ns >= {1'b0, r_g};
    assign dge = ds >= {1'b0, r_g};

    assign limit = PW'(1) << (WIDTH - 1);
    assign ovf   = (r_d > limit - 1'b1) || (r_n > limit) || (r_n == limit && !r_neg);
    assign nw    = r_neg ? (~r_n[WIDTH-1:0] + 1'b1) : r_n[WIDTH-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_job.zden || i_job.nmag == '0) n_state = S_OUT;
                    else n_state = S_GCD;
                end
            end
            S_GCD:  if (r_a == '0) n_state = S_DIV;
            S_DIV:  if (r_cnt == CW'(PW - 1)) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (i_m_tready)              r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_a   <= i_job.nmag;
                r_b   <= i_job.dmag;
                r_neg <= i_job.neg;
                r_k   <= '0;
                r_st  <= i_job.zden ? ST_ZERO_DEN : ST_OK;
                if (!i_job.zden && i_job.nmag == '0) begin
                    r_n <= '0;
                    r_d <= PW'(1);
                end else begin
                    r_n <= i_job.nmag;
                    r_d <= i_job.dmag;
                end
            end
            S_GCD: begin
                // binary gcd; the common power of two is kept in r_k
                if (r_a == '0) begin
                    r_g    <= r_b << r_k;
                    r_nrem <= '0;
                    r_drem <= '0;
                    r_cnt  <= '0;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= (r_a - r_b) >> 1;
                end else begin
                    r_b <= (r_b - r_a) >> 1;
                end
            end
            S_DIV: begin
                r_nrem <= nge ? PW'(ns - {1'b0, r_g}) : PW'(ns);
                r_drem <= dge ? PW'(ds - {1'b0, r_g}) : PW'(ds);
                r_n    <= {r_n[PW-2:0], nge};
                r_d    <= {r_d[PW-2:0], dge};
                r_cnt  <= r_cnt + 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    if (r_st != ST_OK) begin
                        r_res_num <= '0;
                        r_res_den <= '0;
                        r_status  <= r_st;
                    end else if (ovf) begin
                        r_res_num <= '0;
                        r_res_den <= '0;
                        r_status  <= ST_OVERFLOW;
                    end else begin
                        r_res_num <= 32'($signed(nw));
                        r_res_den <= 31'(r_d);
                        r_status  <= ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_res_den, r_res_num};
    assign o_m_tuser  = r_status;

    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_OK) |-> (r_res_den != '0))
        else $error("ok result with zero denominator");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_res_num == '0 && r_res_den == '0))
        else $error("error result carries data");

    a_div_g: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_g != '0))
        else $error("division by zero gcd");

endmodule
`default_nettype wire

/* rtl/rational_add_reduce.sv */
`default_nettype none
// Adds or reduces signed fractions. Each input word carries an opcode (reduce A,
// or add A and B then reduce) and two fractions; each output word carries the
// reduced numerator with the sign, a positive denominator and a status (ok,
// zero denominator, overflow). The front takes a word, forms the cross products
// and the sum exactly at double width, and queues the job. For a nonzero
// numerator and denominator the back finds the gcd by the binary method, one
// shift or subtract per cycle, then divides numerator and denominator by it
// together, one quotient bit per cycle. The front accepts a new word while the
// back is still busy.
module rational_add_reduce import rar_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,  // num_a, den_a, num_b, den_b
    input  wire logic         i_s_tuser,  // opcode
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [63:0]       o_m_tdata,  // res_num, res_den, pad
    output logic [1:0]        o_m_tuser   // status
);

    t_job push_job, pop_job;
    logic push, pop, full, empty;

    rar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_push     (push),
        .o_job      (push_job),
        .i_full     (full)
    );

    rar_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    rar_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (pop_job),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire
